@@ hw/rtl/rtfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfc_pkg
// shared types, opcodes and status codes of the region table fault check
// ----------------------------------------------------------------------------
package rtfc_pkg;

   localparam int MAX_REGIONS_DEF = 16;

   localparam int REQ_W  = 200;   // 197 payload bits padded to bytes
   localparam int RSP_W  = 72;    // 69 payload bits padded to bytes
   localparam int ADDR_W = 64;

   localparam logic [ADDR_W-1:0] PAGE_MASK = 64'hffff_ffff_ffff_f000;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_FAULT  = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_NO_REGION = 3'd3;
   localparam logic [2:0] ST_READ_ONLY = 3'd4;

   typedef struct packed {
      logic              user;
      logic              writable;
      logic [ADDR_W-1:0] end_addr;
      logic [ADDR_W-1:0] start_addr;
   } entry_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [ADDR_W-1:0] region_start;
      logic [ADDR_W-1:0] region_size;
      logic              region_writable;
      logic              region_user;
      logic [ADDR_W-1:0] fault_address;
      logic              fault_is_write;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [ADDR_W-1:0] page_base;
      logic              map_writable;
      logic              map_user;
   } rsp_type;

endpackage

@@ hw/rtl/rtfc_table_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfc_table_mem
// region entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module rtfc_table_mem #(
   parameter int DEPTH = rtfc_pkg::MAX_REGIONS_DEF,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  rtfc_pkg::entry_type wr_data,
   input  logic [IDX_W-1:0]    rd_idx,
   output rtfc_pkg::entry_type rd_data
);
   import rtfc_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/rtfc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfc_ctrl
// operation sequencer: walks the region memory one entry per cycle
// ----------------------------------------------------------------------------
module rtfc_ctrl #(
   parameter int MAX_REGIONS = rtfc_pkg::MAX_REGIONS_DEF,
   parameter int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
   parameter int CNT_W = $clog2(MAX_REGIONS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rtfc_pkg::req_type   req,
   output logic                mem_we,
   output logic [IDX_W-1:0]    mem_waddr,
   output rtfc_pkg::entry_type mem_wdata,
   output logic [IDX_W-1:0]    mem_raddr,
   input  rtfc_pkg::entry_type mem_rdata,
   input  logic                out_free,
   output logic                res_valid,
   output rtfc_pkg::rsp_type   res
);
   import rtfc_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_INS_CMP = 3'd1;
   localparam logic [2:0] S_INS_WR  = 3'd2;
   localparam logic [2:0] S_FLT_CMP = 3'd3;
   localparam logic [2:0] S_DONE    = 3'd4;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   entry_type         new_ff, new_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              wr_ff, wr_in;
   rsp_type           res_ff, res_in;

   logic [CNT_W-1:0]  cnt_m1;
   logic              accept;
   logic              moves;
   logic              hit;

   assign cnt_m1 = count_ff - 1'b1;
   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // entry goes behind the new region (first entry uses strict compare)
   assign moves = (idx_ff == '0) ? (new_ff.start_addr < mem_rdata.start_addr)
                                 : (mem_rdata.start_addr >= new_ff.start_addr);
   assign hit = (addr_ff >= mem_rdata.start_addr) && (addr_ff < mem_rdata.end_addr);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      new_in    = new_ff;
      addr_in   = addr_ff;
      wr_in     = wr_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = new_ff;
      mem_raddr = '0;
      res_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.op == OP_INSERT) begin
               mem_raddr = cnt_m1[IDX_W-1:0];
            end
            if (accept) begin
               new_in.start_addr = req.region_start;
               new_in.end_addr   = req.region_start + req.region_size;
               new_in.writable   = req.region_writable;
               new_in.user       = req.region_user;
               addr_in           = req.fault_address;
               wr_in             = req.fault_is_write;
               res_in            = '0;
               res_in.status     = ST_OK;
               state_in          = S_DONE;
               case (req.op)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_INSERT: begin
                     if (req.region_size == '0) begin
                        res_in.status = ST_ZERO_SIZE;
                     end else if (count_ff >= CNT_MAX) begin
                        res_in.status = ST_FULL;
                     end else if (count_ff == '0) begin
                        idx_in   = '0;
                        state_in = S_INS_WR;
                     end else begin
                        idx_in   = cnt_m1[IDX_W-1:0];
                        state_in = S_INS_CMP;
                     end
                  end
                  OP_FAULT: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_NO_REGION;
                     end else begin
                        idx_in   = '0;
                        state_in = S_FLT_CMP;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_INS_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff + 1'b1;
            if (moves) begin
               // shift one slot up, keep walking down
               mem_wdata = mem_rdata;
               if (idx_ff == '0) begin
                  state_in = S_INS_WR;
               end else begin
                  idx_in    = idx_ff - 1'b1;
                  mem_raddr = idx_ff - 1'b1;
               end
            end else begin
               mem_wdata = new_ff;
               count_in  = count_ff + 1'b1;
               state_in  = S_DONE;
            end
         end
         S_INS_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = new_ff;
            count_in  = count_ff + 1'b1;
            state_in  = S_DONE;
         end
         S_FLT_CMP: begin
            if (hit) begin
               state_in = S_DONE;
               if (wr_ff && !mem_rdata.writable) begin
                  res_in.status = ST_READ_ONLY;
               end else begin
                  res_in.page_base    = addr_ff & PAGE_MASK;
                  res_in.map_writable = mem_rdata.writable;
                  res_in.map_user     = mem_rdata.user;
               end
            end else if ((CNT_W'(idx_ff) + 1'b1) == count_ff) begin
               res_in.status = ST_NO_REGION;
               state_in      = S_DONE;
            end else begin
               idx_in    = idx_ff + 1'b1;
               mem_raddr = idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            res_valid = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      new_ff  <= new_in;
      addr_ff <= addr_in;
      wr_ff   <= wr_in;
      res_ff  <= res_in;
   end

   assign res = res_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("region count above table depth");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> state_ff == S_IDLE)
      else $error("sequencer not idle after result");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> CNT_W'(mem_waddr) <= count_ff)
      else $error("table write past end of occupied entries");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && req.op == OP_CLEAR |=> count_ff == '0)
      else $error("clear did not empty the table");

endmodule

@@ hw/rtl/region_table_fault_check_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_table_fault_check_core
// sorted address region table with insert, clear and fault lookup
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one operation per beat (clear, insert region, fault lookup);
//   rsp_* returns exactly one result beat per request, in request order.
//   regions live in a single memory with a registered read; the
//   sequencer visits one entry per cycle.
// sequencing of a request:
//   clear, rejected insert, lookup in empty table, unused op: no table walk
//   insert into a non-empty table: walks down from the last entry, shifting
//   entries up one slot until the slot of the new region is found
//   fault: walks up from the first entry to the first match or the last entry
//   one request is worked at a time; the next request is taken only once
//   the sequencer has passed its result on and is idle again
// reset: clears the region count (table empty) and drops any pending result;
//   memory contents are never used before being written
// stall: a finished result sits in the output register; the sequencer takes
//   the next request meanwhile and holds its own result until the register
//   frees up
// ----------------------------------------------------------------------------
module region_table_fault_check_core #(
   parameter int MAX_REGIONS = rtfc_pkg::MAX_REGIONS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // op[1:0], region_start[65:2], region_size[129:66], region_writable[130],
   // region_user[131], fault_address[195:132], fault_is_write[196], zero pad
   input  logic [rtfc_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // status[2:0], page_base[66:3], map_writable[67], map_user[68], zero pad
   output logic [rtfc_pkg::RSP_W-1:0] rsp_tdata
);
   import rtfc_pkg::*;

   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);

   req_type          req;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic [IDX_W-1:0] mem_raddr;
   entry_type        mem_rdata;
   logic             res_valid;
   rsp_type          res;
   logic             out_free;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;

   // unpack the request beat
   assign req.op              = req_tdata[1:0];
   assign req.region_start    = req_tdata[65:2];
   assign req.region_size     = req_tdata[129:66];
   assign req.region_writable = req_tdata[130];
   assign req.region_user     = req_tdata[131];
   assign req.fault_address   = req_tdata[195:132];
   assign req.fault_is_write  = req_tdata[196];

   rtfc_table_mem #(
      .DEPTH (MAX_REGIONS),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_idx  (mem_waddr),
      .wr_data (mem_wdata),
      .rd_idx  (mem_raddr),
      .rd_data (mem_rdata)
   );

   rtfc_ctrl #(
      .MAX_REGIONS (MAX_REGIONS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register: free when empty or being drained this cycle
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff.map_user, rsp_data_ff.map_writable,
                        rsp_data_ff.page_base, rsp_data_ff.status};

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !res_valid)
      else $error("result loaded over a stalled beat");

   a_ok_base_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.page_base[11:0] == 12'h000)
      else $error("page base not page aligned");

   a_err_no_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != ST_OK |->
         !rsp_data_ff.map_writable && !rsp_data_ff.map_user)
      else $error("mapping bits set on an error result");

endmodule

@@ tb/region_table_fault_check_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_table_fault_check_core_tb
// self-checking bench for the sorted region table with clear, insert and
// fault lookup: a scoreboard class keeps its own copy of the region table,
// predicts one result per accepted request beat and compares every result
// beat field by field; directed corner cases come first, then a long random
// run with bursty requests, a stalling receiver, one long hold-off and one
// full drain in the middle
// ----------------------------------------------------------------------------
module region_table_fault_check_core_tb;
   import rtfc_pkg::*;

   localparam int          HALF_PERIOD   = 5;
   localparam int          RANDOM_ITEMS  = 1750;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          DRAIN_CYCLES  = 40;
   localparam int          WATCHDOG_NS   = 5_000_000;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;  // op code with no meaning
   localparam logic [63:0] ALL_ONES      = 64'hffff_ffff_ffff_ffff;

   // --------------------------------------------------------------------------
   // region table predictor and result checker
   // --------------------------------------------------------------------------
   class region_table_scoreboard;
      logic [ADDR_W-1:0] start_tab [MAX_REGIONS_DEF];
      logic [ADDR_W-1:0] end_tab   [MAX_REGIONS_DEF];
      logic [1:0]        mark_tab  [MAX_REGIONS_DEF];   // bit 0 writable, bit 1 user
      int                region_count;
      rsp_type           pending_results [$];
      int                mismatch_count;

      function new();
         region_count   = 0;
         mismatch_count = 0;
      endfunction

      // zero size is rejected before fullness is looked at
      function logic [2:0] insert_region(input logic [ADDR_W-1:0] base,
                                         input logic [ADDR_W-1:0] size,
                                         input logic [1:0]        mark);
         int slot;
         if (size == '0)
            return ST_ZERO_SIZE;
         if (region_count >= MAX_REGIONS_DEF)
            return ST_FULL;
         // front if empty or below the first start, else scan from entry one
         if (region_count == 0 || base < start_tab[0]) begin
            slot = 0;
         end else begin
            slot = 1;
            while (slot < region_count && start_tab[slot] < base)
               slot++;
         end
         for (int i = region_count; i > slot; i--) begin
            start_tab[i] = start_tab[i-1];
            end_tab[i]   = end_tab[i-1];
            mark_tab[i]  = mark_tab[i-1];
         end
         start_tab[slot] = base;
         end_tab[slot]   = base + size;   // wraps modulo 2^64
         mark_tab[slot]  = mark;
         region_count++;
         return ST_OK;
      endfunction

      function void note_request(input req_type r);
         rsp_type e;
         int      hit;
         e = '0;
         case (r.op)
            OP_CLEAR: begin
               region_count = 0;
            end
            OP_INSERT: begin
               e.status = insert_region(r.region_start, r.region_size,
                                        {r.region_user, r.region_writable});
            end
            OP_FAULT: begin
               hit = -1;
               for (int i = 0; i < region_count; i++)
                  if (hit < 0 && r.fault_address >= start_tab[i] &&
                      r.fault_address < end_tab[i])
                     hit = i;
               if (hit < 0) begin
                  e.status = ST_NO_REGION;
               end else if (r.fault_is_write && !mark_tab[hit][0]) begin
                  e.status = ST_READ_ONLY;
               end else begin
                  e.page_base    = r.fault_address & PAGE_MASK;
                  e.map_writable = mark_tab[hit][0];
                  e.map_user     = mark_tab[hit][1];
               end
            end
            default: ;
         endcase
         pending_results.push_back(e);
      endfunction

      task report_mismatch(input string what, input logic [63:0] got,
                           input logic [63:0] want);
         $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
         mismatch_count++;
      endtask

      task check_result(input logic [RSP_W-1:0] d);
         rsp_type e;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat, status", 64'(d[2:0]), '0);
         end else begin
            e = pending_results.pop_front();
            if (d[2:0] !== e.status)
               report_mismatch("status", 64'(d[2:0]), 64'(e.status));
            if (d[66:3] !== e.page_base)
               report_mismatch("page_base", d[66:3], e.page_base);
            if (d[67] !== e.map_writable)
               report_mismatch("map_writable", 64'(d[67]), 64'(e.map_writable));
            if (d[68] !== e.map_user)
               report_mismatch("map_user", 64'(d[68]), 64'(e.map_user));
         end
      endtask
   endclass

   // --------------------------------------------------------------------------
   // clock, reset and the block
   // --------------------------------------------------------------------------
   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;

   region_table_scoreboard sb = new();

   // sender pacing and generator state
   int          burst_left   = 1;
   bit          hold_request = 1'b0;
   logic [63:0] window_base  = 64'h0000_0000_0010_0000;

   always #(HALF_PERIOD) clock = ~clock;

   region_table_fault_check_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // --------------------------------------------------------------------------
   // request beat builders
   // --------------------------------------------------------------------------
   // every field random so that unused fields toggle too
   function automatic req_type random_fields();
      req_type r;
      r.op              = 2'($urandom_range(0, 3));
      r.region_start    = {$urandom, $urandom};
      r.region_size     = {$urandom, $urandom};
      r.region_writable = 1'($urandom_range(0, 1));
      r.region_user     = 1'($urandom_range(0, 1));
      r.fault_address   = {$urandom, $urandom};
      r.fault_is_write  = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic req_type make_op(input logic [1:0] op);
      req_type r;
      r    = random_fields();
      r.op = op;
      return r;
   endfunction

   function automatic req_type make_insert(input logic [63:0] base, input logic [63:0] size,
                                           input logic writable, input logic user);
      req_type r;
      r                 = make_op(OP_INSERT);
      r.region_start    = base;
      r.region_size     = size;
      r.region_writable = writable;
      r.region_user     = user;
      return r;
   endfunction

   function automatic req_type make_fault(input logic [63:0] addr, input logic is_write);
      req_type r;
      r                = make_op(OP_FAULT);
      r.fault_address  = addr;
      r.fault_is_write = is_write;
      return r;
   endfunction

   // mostly well-formed traffic inside a moving address window: inserts that
   // land between, on and next to existing regions, and faults that probe
   // region edges; the rest is clears, rejects, the unused op and raw noise
   function automatic req_type next_random_item();
      req_type     r;
      int          pick;
      int          idx;
      logic [63:0] lo;
      logic [63:0] hi;
      r    = random_fields();
      pick = $urandom_range(0, 99);
      if (pick < 4 || (sb.region_count == MAX_REGIONS_DEF && pick < 35)) begin
         r.op = OP_CLEAR;
         case ($urandom_range(0, 5))
            0:       window_base = 64'h0;
            1:       window_base = 64'hffff_ffff_fffc_0000;   // invites wrapping ends
            default: window_base = {$urandom, $urandom} & PAGE_MASK;
         endcase
      end else if (pick < 6) begin
         r.op = OP_UNUSED;
      end else if (pick < 9) begin
         r.op          = OP_INSERT;
         r.region_size = '0;
      end else if (pick < 14) begin
         // raw noise, fields as drawn
      end else if (pick < 52) begin
         r.op = OP_INSERT;
         if (sb.region_count > 0 && $urandom_range(0, 5) == 0)
            r.region_start = sb.start_tab[$urandom_range(0, sb.region_count - 1)];
         else
            r.region_start = window_base + 64'($urandom_range(0, 'h3ffff));
         if ($urandom_range(0, 7) == 0)
            r.region_size = {$urandom, $urandom};
         else
            r.region_size = 64'($urandom_range(1, 'hffff));
      end else begin
         r.op = OP_FAULT;
         if (sb.region_count > 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, sb.region_count - 1);
            lo  = sb.start_tab[idx];
            hi  = sb.end_tab[idx];
            case ($urandom_range(0, 4))
               0:       r.fault_address = lo;
               1:       r.fault_address = hi - 64'd1;
               2:       r.fault_address = hi;
               3:       r.fault_address = lo - 64'd1;
               default: r.fault_address = lo + 64'($urandom_range(0, 'hffff));
            endcase
         end else begin
            r.fault_address = window_base + 64'($urandom_range(0, 'h4ffff));
         end
      end
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // sender
   // --------------------------------------------------------------------------
   task automatic idle_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // offer one beat and hold it until accepted, then pace the next one
   task automatic send_request(input req_type r);
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, r.fault_is_write, r.fault_address, r.region_user,
                     r.region_writable, r.region_size, r.region_start, r.op};
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0)
            idle_sender($urandom_range(1, 12));
      end
   endtask

   task automatic wait_for_drain();
      idle_sender(1);
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // receiver: stalls in segments of random mode, one long hold-off on request
   // --------------------------------------------------------------------------
   initial begin
      int len;
      int mode;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            len  = $urandom_range(5, 60);
            mode = $urandom_range(0, 2);
            repeat (len) begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= ($urandom_range(0, 2) != 0);
                  default: rsp_tready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
   end

   // --------------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty table: clear, lookup miss, unused op, zero size
      send_request(make_op(OP_CLEAR));
      send_request(make_fault(64'h0, 1'b0));
      send_request(make_op(OP_UNUSED));
      send_request(make_insert(64'h1000, 64'h0, 1'b1, 1'b1));
      // top start with an end that wraps to zero, contains nothing
      send_request(make_insert(ALL_ONES, 64'h1, 1'b1, 1'b1));
      send_request(make_fault(ALL_ONES, 1'b0));
      // start below the first one goes to the front; largest size, read-only
      send_request(make_insert(64'h0, ALL_ONES - 64'h0, 1'b0, 1'b1));
      send_request(make_fault(64'h1234, 1'b1));
      send_request(make_fault(64'hffff_ffff_ffff_fffe, 1'b0));
      // equal start to the first entry lands behind it, first entry still wins
      send_request(make_insert(64'h0, 64'h2000, 1'b1, 1'b0));
      send_request(make_fault(64'h10, 1'b1));
      send_request(make_fault(ALL_ONES, 1'b1));
      // fill the table, then overflow it and check zero size takes priority
      for (int k = 0; k < 13; k++)
         send_request(make_insert(64'h0010_0000 + 64'(k) * 64'h1_0000, 64'h800 + 64'(k),
                                  1'(k), 1'(k >> 1)));
      send_request(make_insert(64'h0000_0000_0008_0000, 64'h10, 1'b1, 1'b1));
      send_request(make_insert(64'h0000_0000_0008_0000, 64'h0, 1'b1, 1'b1));
      send_request(make_op(OP_CLEAR));
      send_request(make_fault(64'h10, 1'b0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300)
            hold_request = 1'b1;   // block fills up while the sender keeps going
         if (n == 1000)
            wait_for_drain();
         send_request(next_random_item());
      end

      // everything offered: wait for the last results and a quiet tail
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // watchdog
   initial begin
      #(WATCHDOG_NS);
      $display("timeout waiting for result beats");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/rtfc_pkg.sv
hw/rtl/rtfc_table_mem.sv
hw/rtl/rtfc_ctrl.sv
hw/rtl/region_table_fault_check_core.sv
tb/region_table_fault_check_core_tb.sv
